// ----- hdl/text_cell_buffer_with_scroll_assert.svh -----
// Assertion macros for the text cell buffer.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef TEXT_CELL_BUFFER_WITH_SCROLL_ASSERT_SVH
`define TEXT_CELL_BUFFER_WITH_SCROLL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tcb_pkg.sv -----
// Shared types and constants for the text cell buffer.
// No dependencies.
`default_nettype none
package tcb_pkg;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'h20;

	typedef enum logic [2:0] {
		OP_WRITE_CHAR    = 3'd0,
		OP_POKE          = 3'd1,
		OP_READ_CELL     = 3'd2,
		OP_CLEAR_SCREEN  = 3'd3,
		OP_CLEAR_INVERT  = 3'd4,
		OP_INVERT_ROW    = 3'd5,
		OP_MARK_RENDERED = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_PAD,
		ST_COPY,
		ST_FILL,
		ST_CLR_CHAR,
		ST_CLR_INV,
		ST_INV_ROW,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ----- hdl/text_cell_buffer_with_scroll.sv -----
// Text cell buffer: a one-cell command goes from idle to a done state, which loads the result.
// A write_char that scrolls adds a row copy, then blanking. Newline adds space padding to the
// line end; clear_screen and clear_invert add a pass over every cell, invert_row over its row.
// One command is in work at a time; a held result does not block the next. After reset a
// clearing pass over every cell fills both RAMs; no transfer is taken then.
// Depends on tcb_pkg, tcb_ram and text_cell_buffer_with_scroll_assert.svh.
`default_nettype none
`include "text_cell_buffer_with_scroll_assert.svh"
module text_cell_buffer_with_scroll
	import tcb_pkg::*;
#(
	parameter int TEXT_COLUMNS = 21,
	parameter int TEXT_ROWS    = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [2:0] operation,
	input  wire  [7:0] char_code,
	input  wire  [4:0] column,
	input  wire  [2:0] row,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] cell_char,
	output logic       cell_inverted,
	output logic [6:0] cursor_index,
	output logic       screen_dirty
);

	localparam int COLS  = TEXT_COLUMNS;
	localparam int ROWS  = TEXT_ROWS;
	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLS);
	localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
	localparam logic [AW-1:0] SCROLL_BASE = AW'(COLS * (ROWS - 1));
	localparam logic [CW-1:0] LAST_COL    = CW'(COLS - 1);

	state_t        state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] cursor_q, cursor_d;
	logic [CW-1:0] col_q, col_d;
	logic          dirty_q, dirty_d;
	logic          read_q, read_d;
	logic          cp_wr_s1, cp_wr_d;
	logic [AW-1:0] cp_addr_s1, cp_addr_d;
	logic          out_valid_q;
	logic          out_load;
	logic [7:0]    cell_char_q;
	logic          cell_inverted_q;
	logic [6:0]    cursor_index_q;
	logic          screen_dirty_q;

	logic          ch_we, ch_re, inv_we, inv_re;
	logic [AW-1:0] ch_waddr, ch_raddr, inv_waddr, inv_raddr;
	logic [7:0]    ch_wdata, ch_rdata;
	logic          inv_wdata, inv_rdata;

	logic          row_ok, cell_ok;
	logic [AW-1:0] cell_idx, row_base;
	logic          cur_last, col_last, ptr_last, cnt_last;
	logic [AW-1:0] cursor_adv;
	logic [CW-1:0] col_adv;
	logic [AW+6:0] cursor_ext;

	assign row_ok   = int'(row) < ROWS;
	assign cell_ok  = row_ok && (int'(column) < COLS);
	assign row_base = AW'(int'(row) * COLS);
	assign cell_idx = cell_ok ? AW'(int'(row) * COLS + int'(column)) : '0;

	assign cur_last   = cursor_q == LAST_CELL;
	assign col_last   = col_q == LAST_COL;
	assign ptr_last   = ptr_q == LAST_CELL;
	assign cnt_last   = cnt_q == LAST_COL;
	// The last cell wraps into a scroll, which leaves the cursor at the start of the bottom row.
	assign cursor_adv = cur_last ? SCROLL_BASE : cursor_q + 1'b1;
	assign col_adv    = col_last ? '0 : col_q + 1'b1;
	assign cursor_ext = {7'd0, cursor_q};

	assign in_stall      = state_q != ST_IDLE;
	assign out_valid     = out_valid_q;
	assign cell_char     = cell_char_q;
	assign cell_inverted = cell_inverted_q;
	assign cursor_index  = cursor_index_q;
	assign screen_dirty  = screen_dirty_q;

	tcb_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (ch_wdata),
		.re    (ch_re),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	tcb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_inv_ram (
		.clk   (clk),
		.we    (inv_we),
		.waddr (inv_waddr),
		.wdata (inv_wdata),
		.re    (inv_re),
		.raddr (inv_raddr),
		.rdata (inv_rdata)
	);

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		cnt_d     = cnt_q;
		cursor_d  = cursor_q;
		col_d     = col_q;
		dirty_d   = dirty_q;
		read_d    = read_q;
		cp_wr_d   = 1'b0;
		cp_addr_d = ptr_q - AW'(COLS);
		out_load  = 1'b0;
		ch_we     = 1'b0;
		ch_waddr  = cursor_q;
		ch_wdata  = SPACE_CODE;
		ch_re     = 1'b0;
		ch_raddr  = ptr_q;
		inv_we    = 1'b0;
		inv_waddr = ptr_q;
		inv_wdata = 1'b0;
		inv_re    = 1'b0;
		inv_raddr = cell_idx;

		case (state_q)
			ST_INIT: begin
				ch_we    = 1'b1;
				ch_waddr = ptr_q;
				inv_we   = 1'b1;
				if (ptr_last) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					read_d  = 1'b0;
					state_d = ST_DONE;
					case (op_t'(operation))
						OP_WRITE_CHAR: begin
							dirty_d = 1'b1;
							if (char_code == NEWLINE_CODE) begin
								state_d = ST_PAD;
							end else begin
								ch_we    = 1'b1;
								ch_wdata = char_code;
								cursor_d = cursor_adv;
								col_d    = col_adv;
								if (cur_last) begin
									ptr_d   = AW'(COLS);
									state_d = ST_COPY;
								end
							end
						end
						OP_POKE: begin
							ch_we    = cell_ok;
							ch_waddr = cell_idx;
							ch_wdata = char_code;
						end
						OP_READ_CELL: begin
							ch_re    = 1'b1;
							ch_raddr = cell_idx;
							inv_re   = 1'b1;
							read_d   = cell_ok;
						end
						OP_CLEAR_SCREEN: begin
							ptr_d    = '0;
							cursor_d = '0;
							col_d    = '0;
							dirty_d  = 1'b1;
							state_d  = ST_CLR_CHAR;
						end
						OP_CLEAR_INVERT: begin
							ptr_d   = '0;
							state_d = ST_CLR_INV;
						end
						OP_INVERT_ROW: begin
							if (row_ok) begin
								ptr_d   = row_base;
								cnt_d   = '0;
								state_d = ST_INV_ROW;
							end
						end
						OP_MARK_RENDERED: begin
							dirty_d = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_PAD: begin
				// A newline pads with spaces up to the end of the line, one cell a cycle.
				ch_we    = 1'b1;
				cursor_d = cursor_adv;
				col_d    = col_adv;
				if (col_last) begin
					if (cur_last) begin
						ptr_d   = AW'(COLS);
						state_d = ST_COPY;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_COPY: begin
				// Reads run one row ahead of the writes, so no entry is read after it is moved.
				ch_re     = 1'b1;
				cp_wr_d   = 1'b1;
				cp_addr_d = ptr_q - AW'(COLS);
				if (ptr_last) begin
					ptr_d   = SCROLL_BASE;
					state_d = ST_FILL;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_FILL: begin
				// The last copied entry still owns the write port in the first cycle here.
				if (!cp_wr_s1) begin
					ch_we    = 1'b1;
					ch_waddr = ptr_q;
					if (ptr_last) begin
						state_d = ST_DONE;
					end else begin
						ptr_d = ptr_q + 1'b1;
					end
				end
			end
			ST_CLR_CHAR: begin
				ch_we    = 1'b1;
				ch_waddr = ptr_q;
				if (ptr_last) begin
					state_d = ST_DONE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_CLR_INV: begin
				inv_we = 1'b1;
				if (ptr_last) begin
					state_d = ST_DONE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_INV_ROW: begin
				inv_we    = 1'b1;
				inv_wdata = 1'b1;
				if (cnt_last) begin
					state_d = ST_DONE;
				end else begin
					ptr_d = ptr_q + 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (cp_wr_s1) begin
			ch_we    = 1'b1;
			ch_waddr = cp_addr_s1;
			ch_wdata = ch_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			cnt_q       <= '0;
			cursor_q    <= '0;
			col_q       <= '0;
			dirty_q     <= 1'b1;
			read_q      <= 1'b0;
			cp_wr_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ptr_q    <= ptr_d;
			cnt_q    <= cnt_d;
			cursor_q <= cursor_d;
			col_q    <= col_d;
			dirty_q  <= dirty_d;
			read_q   <= read_d;
			cp_wr_s1 <= cp_wr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cp_addr_d;
		if (out_load) begin
			cell_char_q     <= read_q ? ch_rdata : 8'd0;
			cell_inverted_q <= read_q ? inv_rdata : 1'b0;
			cursor_index_q  <= cursor_ext[6:0];
			screen_dirty_q  <= dirty_q;
		end
	end

	`TCB_ASSERT_IMPL(a_cursor_range, 1'b1, cursor_q <= LAST_CELL, "cursor beyond last cell")
	`TCB_ASSERT_IMPL(a_col_range, 1'b1, col_q <= LAST_COL, "cursor column beyond last column")
	`TCB_ASSERT_IMPL(a_copy_order, cp_wr_s1 && state_q == ST_COPY, cp_addr_s1 < ptr_q, "scroll write overtook its read")
	`TCB_ASSERT_NEXT(a_done_handoff, state_q == ST_DONE && (!out_valid_q || !out_stall), state_q == ST_IDLE && out_valid_q, "result not handed to output register")

endmodule
`default_nettype wire

// ----- hdl/tcb_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module tcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 84
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- tb/tcb_tb_pkg.sv -----
// Scoreboard for the text cell buffer testbench: a screen model and a queue of expected results.
// Depends on tcb_pkg for the command codes and the space and newline characters.
`timescale 1ns / 1ps
package tcb_tb_pkg;
	import tcb_pkg::*;

	localparam int TEXT_COLUMNS = 21;
	localparam int TEXT_ROWS    = 4;
	localparam int CELL_COUNT   = TEXT_COLUMNS * TEXT_ROWS;
	localparam logic [2:0] OP_RESERVED = 3'd7;
	localparam int REPORT_LINES = 200;

	typedef struct packed {
		logic [7:0] cell_char;
		logic       cell_inverted;
		logic [6:0] cursor_index;
		logic       screen_dirty;
	} cell_result_t;

	class screen_scoreboard;
		logic [7:0]   screen_chars [CELL_COUNT];
		logic         screen_marks [CELL_COUNT];
		int unsigned  cursor;
		logic         dirty;
		cell_result_t expected_q [$];
		int unsigned  result_count;
		int unsigned  mismatches;

		function new();
			foreach (screen_chars[i]) begin
				screen_chars[i] = SPACE_CODE;
				screen_marks[i] = 1'b0;
			end
			cursor = 0;
			dirty = 1'b1;
			result_count = 0;
			mismatches = 0;
		endfunction

		// Stepping off the last cell moves every row up and blanks the bottom one.
		function void put_char(logic [7:0] code);
			if (cursor >= CELL_COUNT) cursor = 0;
			screen_chars[cursor] = code;
			cursor++;
			if (cursor == CELL_COUNT) begin
				for (int i = 0; i < CELL_COUNT - TEXT_COLUMNS; i++)
					screen_chars[i] = screen_chars[i + TEXT_COLUMNS];
				cursor = CELL_COUNT - TEXT_COLUMNS;
				for (int i = CELL_COUNT - TEXT_COLUMNS; i < CELL_COUNT; i++)
					screen_chars[i] = SPACE_CODE;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_input(logic [2:0] op, logic [7:0] code, logic [4:0] col,
				logic [2:0] row);
			cell_result_t res;
			bit           in_range;
			int unsigned  cell_addr;
			in_range = (col < TEXT_COLUMNS) && (row < TEXT_ROWS);
			cell_addr = in_range ? row * TEXT_COLUMNS + col : 0;
			res = '0;
			case (op)
			OP_WRITE_CHAR: begin
				dirty = 1'b1;
				// The pad count is fixed by the column at the start, even across a scroll.
				if (code == NEWLINE_CODE) begin
					for (int c = cursor % TEXT_COLUMNS; c < TEXT_COLUMNS; c++)
						put_char(SPACE_CODE);
				end else begin
					put_char(code);
				end
			end
			OP_POKE: begin
				if (in_range) screen_chars[cell_addr] = code;
			end
			OP_READ_CELL: begin
				if (in_range) begin
					res.cell_char = screen_chars[cell_addr];
					res.cell_inverted = screen_marks[cell_addr];
				end
			end
			OP_CLEAR_SCREEN: begin
				foreach (screen_chars[i]) screen_chars[i] = SPACE_CODE;
				cursor = 0;
				dirty = 1'b1;
			end
			OP_CLEAR_INVERT: begin
				foreach (screen_marks[i]) screen_marks[i] = 1'b0;
			end
			OP_INVERT_ROW: begin
				if (row < TEXT_ROWS)
					for (int c = 0; c < TEXT_COLUMNS; c++)
						screen_marks[row * TEXT_COLUMNS + c] = 1'b1;
			end
			OP_MARK_RENDERED: begin
				dirty = 1'b0;
			end
			default: begin
			end
			endcase
			res.cursor_index = cursor[6:0];
			res.screen_dirty = dirty;
			expected_q.push_back(res);
		endfunction

		task report(string msg);
			if (mismatches < REPORT_LINES)
				$display("[%0t] result %0d: %s", $time, result_count, msg);
			mismatches++;
		endtask

		task check_result(logic [7:0] got_char, logic got_inv, logic [6:0] got_cursor,
				logic got_dirty);
			cell_result_t want;
			if (expected_q.size() == 0) begin
				report("result transfer arrived with nothing expected");
			end else begin
				want = expected_q.pop_front();
				if (got_char !== want.cell_char)
					report($sformatf("cell_char got %h, expected %h",
						got_char, want.cell_char));
				if (got_inv !== want.cell_inverted)
					report($sformatf("cell_inverted got %b, expected %b",
						got_inv, want.cell_inverted));
				if (got_cursor !== want.cursor_index)
					report($sformatf("cursor_index got %0d, expected %0d",
						got_cursor, want.cursor_index));
				if (got_dirty !== want.screen_dirty)
					report($sformatf("screen_dirty got %b, expected %b",
						got_dirty, want.screen_dirty));
			end
			result_count++;
		endtask
	endclass

endpackage

// ----- tb/tb_top.sv -----
// Top level of the text cell buffer testbench: clock, reset, command driver and result monitor.
// Depends on tcb_pkg, tcb_tb_pkg and the text_cell_buffer_with_scroll RTL.
`timescale 1ns / 1ps
module tb_top;
	import tcb_pkg::*;
	import tcb_tb_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 200;
	localparam int RANDOM_ITEMS  = 1100;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] operation;
	logic [7:0] char_code;
	logic [4:0] column;
	logic [2:0] row;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] cell_char;
	logic       cell_inverted;
	logic [6:0] cursor_index;
	logic       screen_dirty;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_request = 1'b0;

	screen_scoreboard screen = new();

	text_cell_buffer_with_scroll #(
		.TEXT_COLUMNS(TEXT_COLUMNS),
		.TEXT_ROWS(TEXT_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.char_code(char_code),
		.column(column),
		.row(row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_char(cell_char),
		.cell_inverted(cell_inverted),
		.cursor_index(cursor_index),
		.screen_dirty(screen_dirty)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Valid is left high after a transfer; the next call either replaces the payload or
	// lowers valid within the same time step.
	task automatic send_item(logic [2:0] op, logic [7:0] code, logic [4:0] col,
			logic [2:0] r);
		if (send_idle_pct != 0) begin
			while ($urandom_range(0, 99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		operation <= op;
		char_code <= code;
		column <= col;
		row <= r;
		do @(posedge clk); while (in_stall !== 1'b0);
		screen.note_input(op, code, col, r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (screen.pending() != 0) @(posedge clk);
	endtask

	task automatic run_phase(int unsigned count, int unsigned send_pct,
			int unsigned recv_pct, bit with_hold);
		int unsigned done;
		int unsigned pick;
		bit          hold_sent;
		logic [2:0]  op;
		logic [7:0]  code;
		logic [4:0]  col;
		logic [2:0]  r;
		done = 0;
		hold_sent = 1'b0;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		while (done < count) begin
			if (with_hold && !hold_sent && done >= count / 2) begin
				hold_request = 1'b1;
				hold_sent = 1'b1;
			end
			pick = $urandom_range(0, 99);
			code = $urandom_range(0, 255);
			col = $urandom_range(0, TEXT_COLUMNS - 1);
			r = $urandom_range(0, TEXT_ROWS - 1);
			if (pick < 45) begin
				op = OP_WRITE_CHAR;
				pick = $urandom_range(0, 99);
				if (pick < 25) code = NEWLINE_CODE;
				else if (pick < 80) code = $urandom_range(8'h20, 8'h7e);
			end else if (pick < 60) begin
				op = OP_READ_CELL;
			end else if (pick < 68) begin
				op = OP_POKE;
			end else if (pick < 72) begin
				op = OP_INVERT_ROW;
			end else if (pick < 75) begin
				op = OP_CLEAR_INVERT;
			end else if (pick < 80) begin
				op = OP_MARK_RENDERED;
			end else begin
				op = $urandom_range(0, OP_RESERVED);
				col = $urandom_range(0, 31);
				r = $urandom_range(0, 7);
				// Frequent clears would keep the cursor from ever reaching a scroll.
				if (op == OP_CLEAR_SCREEN && $urandom_range(0, 9) != 0) op = OP_READ_CELL;
			end
			send_item(op, code, col, r);
			if (!(op == OP_RESERVED
					|| (op == OP_POKE && (col >= TEXT_COLUMNS || r >= TEXT_ROWS))
					|| (op == OP_INVERT_ROW && r >= TEXT_ROWS)))
				done++;
		end
	endtask

	// Receiver: random stalls per phase, plus one long hold-off counted here.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			screen.check_result(cell_char, cell_inverted, cursor_index, screen_dirty);
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_WRITE_CHAR;
		char_code = 8'h00;
		column = 5'd0;
		row = 3'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_READ_CELL, 8'h00, 5'd0, 3'd0);
		send_item(OP_MARK_RENDERED, 8'h00, 5'd0, 3'd0);
		send_item(OP_POKE, 8'hff, 5'd20, 3'd3);
		// Pokes outside the screen must leave the store alone.
		send_item(OP_POKE, 8'h55, 5'd21, 3'd0);
		send_item(OP_POKE, 8'haa, 5'd0, 3'd4);
		send_item(OP_POKE, 8'h00, 5'd31, 3'd7);
		send_item(OP_READ_CELL, 8'h00, 5'd20, 3'd3);
		send_item(OP_READ_CELL, 8'hff, 5'd31, 3'd7);
		send_item(OP_INVERT_ROW, 8'h00, 5'd0, 3'd3);
		send_item(OP_INVERT_ROW, 8'h00, 5'd0, 3'd7);
		send_item(OP_READ_CELL, 8'h00, 5'd5, 3'd3);
		send_item(OP_CLEAR_INVERT, 8'h00, 5'd0, 3'd0);
		send_item(OP_READ_CELL, 8'h00, 5'd20, 3'd3);
		send_item(OP_WRITE_CHAR, 8'h41, 5'd0, 3'd0);
		send_item(OP_WRITE_CHAR, 8'h00, 5'd0, 3'd0);
		send_item(OP_WRITE_CHAR, 8'hff, 5'd0, 3'd0);
		send_item(OP_WRITE_CHAR, NEWLINE_CODE, 5'd0, 3'd0);
		send_item(OP_WRITE_CHAR, NEWLINE_CODE, 5'd0, 3'd0);
		send_item(OP_RESERVED, 8'hff, 5'd31, 3'd7);
		send_item(OP_CLEAR_SCREEN, 8'h00, 5'd0, 3'd0);
		// Four blank lines from the top push the screen through its first scroll.
		repeat (4) send_item(OP_WRITE_CHAR, NEWLINE_CODE, 5'd0, 3'd0);
		send_item(OP_WRITE_CHAR, 8'h7e, 5'd0, 3'd0);
		send_item(OP_READ_CELL, 8'h00, 5'd0, 3'd2);
		wait_drained();

		run_phase(RANDOM_ITEMS / 3, 16, 79, 1'b0);
		wait_drained();
		run_phase(RANDOM_ITEMS / 3, 79, 16, 1'b0);
		run_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 0, 0, 1'b1);

		in_valid <= 1'b0;
		while (screen.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (screen.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
